// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

	// Width of one operand field on the ports.
	localparam int FIELD_W = 16;
	// Internal operand width: a signed field or a 16-bit unsigned pattern both fit.
	localparam int OPND_W  = FIELD_W + 1;
	localparam int PROD_W  = 2 * OPND_W;
	localparam int SUM_W   = PROD_W + 1;
	// Magnitude width of every numerator and denominator before reduction.
	localparam int MAG_W   = 33;
	localparam int RNUM_W  = 33;
	localparam int RDEN_W  = 31;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_CMP = 3'd4;

	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;

	typedef struct packed {
		logic [2:0]                cmd;
		logic signed [FIELD_W-1:0] a_num;
		logic signed [FIELD_W-1:0] a_den;
		logic signed [FIELD_W-1:0] b_num;
		logic signed [FIELD_W-1:0] b_den;
	} rau_in_t;

	typedef struct packed {
		logic signed [RNUM_W-1:0] res_num;
		logic [RDEN_W-1:0]        res_den;
		logic [1:0]               order;
		logic [1:0]               status;
	} rau_out_t;

	// One classified job handed from the front end to the reduction engine.
	typedef struct packed {
		logic                     arith;
		logic signed [SUM_W-1:0]  num;
		logic signed [PROD_W-1:0] den;
		logic [1:0]               order;
		logic [1:0]               status;
	} rau_job_t;

endpackage

`default_nettype wire

// ===== rtl/rau_front.sv =====
// Front end: accepts an item, forms the cross products and classifies the job.
`default_nettype none

module rau_front #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire rau_pkg::rau_in_t item,
	output logic                  busy,
	output logic                  push,
	input  wire logic             full,
	output rau_pkg::rau_job_t     job
);
	import rau_pkg::*;

	localparam int  SIGN_POS  = (OPERAND_WIDTH > FIELD_W) ? FIELD_W - 1 : OPERAND_WIDTH - 1;
	localparam bit  SIGNED_IN = (OPERAND_WIDTH <= FIELD_W);

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_MUL0 = 6'b000010,
		F_MUL1 = 6'b000100,
		F_MUL2 = 6'b001000,
		F_SUM  = 6'b010000,
		F_PUSH = 6'b100000
	} fstate_t;

	// Reads a field as an OPERAND_WIDTH-bit two's complement number, unsigned if wider than FIELD_W.
	function automatic logic signed [OPND_W-1:0] ext_opnd(input logic [FIELD_W-1:0] v);
		logic [OPND_W-1:0] z;
		logic [OPND_W-1:0] r;
		z = {1'b0, v};
		for (int i = 0; i < OPND_W; i++) begin
			if (i < SIGN_POS || !SIGNED_IN) begin
				r[i] = z[i];
			end else begin
				r[i] = z[SIGN_POS];
			end
		end
		return signed'(r);
	endfunction

	fstate_t                  state_q;
	logic [2:0]               cmd_q;
	logic signed [OPND_W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [PROD_W-1:0] p0_q, p1_q, p2_q;
	rau_job_t                 job_q;

	logic signed [OPND_W-1:0] mx, my;
	logic signed [PROD_W-1:0] prod;
	rau_job_t                 job_d;
	logic                     lt, eq, flip;

	// One shared multiplier, stepped through three products.
	always_comb begin
		case (state_q)
			F_MUL0: begin
				mx = an_q;
				my = (cmd_q == CMD_MUL) ? bn_q : bd_q;
			end
			F_MUL1: begin
				mx = ad_q;
				my = bn_q;
			end
			default: begin
				mx = ad_q;
				my = bd_q;
			end
		endcase
		prod = mx * my;
	end

	always_comb begin
		lt   = p0_q < p1_q;
		eq   = p0_q == p1_q;
		flip = ad_q[OPND_W-1] ^ bd_q[OPND_W-1];
		job_d        = '0;
		job_d.order  = ORD_EQUAL;
		job_d.status = ST_OK;
		if (ad_q == '0 || bd_q == '0) begin
			job_d.status = ST_ZERO_DEN;
		end else begin
			case (cmd_q)
				CMD_ADD: begin
					job_d.arith = 1'b1;
					job_d.num   = SUM_W'(p0_q) + SUM_W'(p1_q);
					job_d.den   = p2_q;
				end
				CMD_SUB: begin
					job_d.arith = 1'b1;
					job_d.num   = SUM_W'(p0_q) - SUM_W'(p1_q);
					job_d.den   = p2_q;
				end
				CMD_MUL: begin
					job_d.arith = 1'b1;
					job_d.num   = SUM_W'(p0_q);
					job_d.den   = p2_q;
				end
				CMD_DIV: begin
					if (bn_q == '0) begin
						job_d.status = ST_DIV_ZERO;
					end else begin
						job_d.arith = 1'b1;
						job_d.num   = SUM_W'(p0_q);
						job_d.den   = p1_q;
					end
				end
				CMD_CMP: begin
					if (eq) begin
						job_d.order = ORD_EQUAL;
					end else if (lt ^ flip) begin
						job_d.order = ORD_LESS;
					end else begin
						job_d.order = ORD_GREATER;
					end
				end
				default: begin
					job_d.arith = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_MUL0;
					end
				end
				F_MUL0: state_q <= F_MUL1;
				F_MUL1: state_q <= F_MUL2;
				F_MUL2: state_q <= F_SUM;
				F_SUM:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			cmd_q <= item.cmd;
			an_q  <= ext_opnd(item.a_num);
			ad_q  <= ext_opnd(item.a_den);
			bn_q  <= ext_opnd(item.b_num);
			bd_q  <= ext_opnd(item.b_den);
		end
		if (state_q == F_MUL0) begin
			p0_q <= prod;
		end
		if (state_q == F_MUL1) begin
			p1_q <= prod;
		end
		if (state_q == F_MUL2) begin
			p2_q <= prod;
		end
		if (state_q == F_SUM) begin
			job_q <= job_d;
		end
	end

	assign busy = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !full;
	assign job  = job_q;

	// An arithmetic job never carries a zero denominator into the reduction.
	a_arith_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push && job.arith |-> job.den != '0)
		else $error("arithmetic job with zero denominator");

endmodule

`default_nettype wire

// ===== rtl/rau_queue.sv =====
// Short job queue between the front end and the reduction engine.
`default_nettype none

module rau_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rau_pkg::rau_job_t wr_job,
	output logic                   full,
	input  wire logic              pop,
	output rau_pkg::rau_job_t      rd_job,
	output logic                   empty
);
	import rau_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	rau_job_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_job = mem_q[rd_ptr_q];
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);

	// The fill count never passes the depth, and never wraps below zero.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH) && !(pop && empty))
		else $error("queue overflow or underflow");

endmodule

`default_nettype wire

// ===== rtl/rau_back.sv =====
// Reduction engine: binary GCD, exact division by the divisor and result register.
`default_nettype none

module rau_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              empty,
	input  wire rau_pkg::rau_job_t rd_job,
	output logic                   pop,
	output logic                   done,
	output rau_pkg::rau_out_t      result
);
	import rau_pkg::*;

	localparam int CNT_W = $clog2(MAG_W);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_PREP = 5'b00010,
		B_GCD  = 5'b00100,
		B_DIV  = 5'b01000,
		B_FIN  = 5'b10000
	} bstate_t;

	bstate_t           state_q;
	rau_job_t          job_q;
	logic              neg_q;
	logic [MAG_W-1:0]  u_q, v_q, nd_q, dd_q, rn_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	rau_out_t          result_q;

	logic [SUM_W-1:0]  num_abs;
	logic [PROD_W-1:0] den_abs;
	logic [MAG_W-1:0]  nm, dm;
	logic [MAG_W:0]    rn_sh, rd_sh;
	logic              n_ge, d_ge;
	logic [MAG_W-1:0]  rn_nx, rd_nx;
	logic [MAG_W-1:0]  qn_neg;

	always_comb begin
		num_abs = job_q.num[SUM_W-1] ? -job_q.num : job_q.num;
		den_abs = job_q.den[PROD_W-1] ? -job_q.den : job_q.den;
		nm      = num_abs[MAG_W-1:0];
		dm      = den_abs[MAG_W-1:0];
	end

	// One restoring step on both dividends against the shared divisor.
	always_comb begin
		rn_sh = {rn_q, nd_q[MAG_W-1]};
		rd_sh = {rd_q, dd_q[MAG_W-1]};
		n_ge  = rn_sh >= {1'b0, u_q};
		d_ge  = rd_sh >= {1'b0, u_q};
		rn_nx = n_ge ? MAG_W'(rn_sh - {1'b0, u_q}) : rn_sh[MAG_W-1:0];
		rd_nx = d_ge ? MAG_W'(rd_sh - {1'b0, u_q}) : rd_sh[MAG_W-1:0];
		qn_neg = -nd_q;
	end

	assign pop = (state_q == B_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						if (rd_job.arith) begin
							state_q <= B_PREP;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				B_PREP: begin
					if (nm == '0) begin
						done_q  <= 1'b1;
						state_q <= B_IDLE;
					end else begin
						state_q <= B_GCD;
					end
				end
				B_GCD: begin
					if (u_q == v_q) begin
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (cnt_q == CNT_W'(MAG_W - 1)) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					done_q  <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					job_q <= rd_job;
					result_q.res_num <= '0;
					result_q.res_den <= '0;
					result_q.order   <= rd_job.order;
					result_q.status  <= rd_job.status;
				end
			end
			B_PREP: begin
				neg_q <= job_q.num[SUM_W-1] ^ job_q.den[PROD_W-1];
				u_q   <= nm;
				v_q   <= dm;
				nd_q  <= nm;
				dd_q  <= dm;
				result_q.res_num <= '0;
				result_q.res_den <= RDEN_W'(1);
				result_q.order   <= ORD_EQUAL;
				result_q.status  <= ST_OK;
			end
			B_GCD: begin
				if (u_q == v_q) begin
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= '0;
				end else if (!u_q[0] && !v_q[0]) begin
					// A common factor of two comes out of the divisor and both dividends.
					u_q  <= u_q >> 1;
					v_q  <= v_q >> 1;
					nd_q <= nd_q >> 1;
					dd_q <= dd_q >> 1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q > v_q) begin
					u_q <= (u_q - v_q) >> 1;
				end else begin
					v_q <= (v_q - u_q) >> 1;
				end
			end
			B_DIV: begin
				rn_q  <= rn_nx;
				rd_q  <= rd_nx;
				nd_q  <= {nd_q[MAG_W-2:0], n_ge};
				dd_q  <= {dd_q[MAG_W-2:0], d_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			B_FIN: begin
				result_q.res_num <= signed'(neg_q ? qn_neg : nd_q);
				result_q.res_den <= dd_q[RDEN_W-1:0];
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	// The GCD operands stay nonzero, so the loop always ends with a usable divisor.
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_GCD |-> u_q != '0 && v_q != '0)
		else $error("GCD operand reached zero");

	// A flagged result carries no fraction.
	a_error_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.status != ST_OK |-> result_q.res_num == '0 && result_q.res_den == '0)
		else $error("error result with nonzero fraction");

endmodule

`default_nettype wire

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit: front end, job queue and reduction engine.
// Compare and flagged items go straight from the queue to the result; add, subtract, multiply
// and divide pass the binary GCD loop and the restoring divide unless the numerator is zero.
// The front end takes a new item once it has pushed its job, waiting while the queue is full;
// the reduction engine takes a job from the queue only when it is through with the last one.
// Reset clears all control state asynchronously; the queue is empty and the unit idle after it.
`default_nettype none

module rational_arithmetic_unit_top #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire rau_pkg::rau_in_t item,
	output logic                  busy,
	output logic                  done,
	output rau_pkg::rau_out_t     result
);
	import rau_pkg::*;

	// Jobs pass from the front end to the reduction engine through the queue.
	// Each side stalls only on the queue, so the front end can take the next
	// transfer while the engine still reduces an earlier fraction.
	logic     push, full, pop, empty;
	rau_job_t wr_job, rd_job;

	// The front end reads operands as OPERAND_WIDTH-bit two's complement numbers (unsigned above
	// FIELD_W bits), runs three products through one multiplier and sorts out the special cases.
	rau_front #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.push   (push),
		.full   (full),
		.job    (wr_job)
	);

	rau_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	// The engine reduces by the GCD and presents every result for exactly one
	// cycle with done high; the receiver takes each transfer as it comes.
	rau_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.rd_job (rd_job),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire
